// File: src/tree_lca_alternating_climb_defines.svh
`ifndef TREE_LCA_ALTERNATING_CLIMB_DEFINES_SVH
`define TREE_LCA_ALTERNATING_CLIMB_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst is high
`define TLCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst is high
`define TLCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tlca_pkg.sv
`timescale 1ns / 1ps

package tlca_pkg;

  // Width of every vertex field on the ports
  localparam int VW = 10;

  // Stamp counter restart value (always even, never zero)
  localparam int STAMP_START = 2;

  // Result source on finish
  typedef enum logic [1:0] {
    FIN_EQUAL,
    FIN_MET,
    FIN_MISS
  } fin_kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      capture;
    logic      reduce_step;
    logic      load_write;
    logic      mark_first;
    logic      mark_second;
    logic      par_read;
    logic      stamp_read;
    logic      climb_advance;
    logic      clear_step;
    logic      finish;
    fin_kind_t fin_kind;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_load;
    logic same_vertex;
    logic met;
    logic step_last;
    logic clear_last;
    logic wrap;
  } status_t;

endpackage

// File: src/tlca_datapath.sv
`timescale 1ns / 1ps

module tlca_datapath import tlca_pkg::*; #(
  parameter int NODES      = 1024,
  parameter int STAMP_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output status_t       status,
  input  logic          mode,
  input  logic [VW-1:0] node,
  input  logic [VW-1:0] parent_value,
  input  logic [VW-1:0] first_vertex,
  input  logic [VW-1:0] second_vertex,
  output logic [VW-1:0] ancestor,
  output logic          found
);

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int RW = (IW < VW) ? IW : VW;
  localparam int SW = $clog2(2 * NODES + 1);
  localparam logic [31:0] NODES_W = 32'(NODES);
  localparam logic [SW-1:0] STEP_LAST = SW'(2 * NODES - 1);
  localparam logic [IW-1:0] ADDR_LAST = IW'(NODES - 1);
  localparam logic [STAMP_BITS-1:0] STAMP_INIT = STAMP_BITS'(STAMP_START);

  // Reciprocal of NODES scaled by 2^(2*VW); exact quotient for any VW-bit value
  localparam int RECIP_SH = 2 * VW;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(NODES) - 64'd1) / 64'(NODES));

  // Quotient v / NODES by reciprocal multiplication
  function automatic logic [VW-1:0] mod_quot(input logic [VW-1:0] v);
    logic [VW+RECIP_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, v} * {{VW{1'b0}}, RECIP};
    return prod[RECIP_SH +: VW];
  endfunction

  // Remainder v - q * NODES
  function automatic logic [RW-1:0] mod_rem(input logic [VW-1:0] v, input logic [VW-1:0] q);
    logic [31:0] t;
    t = 32'(v) - 32'(q) * NODES_W;
    return t[RW-1:0];
  endfunction

  logic [VW-1:0] raw_node, raw_par, raw_a, raw_b;
  logic [VW-1:0] quo_node, quo_par, quo_a, quo_b;
  logic [RW-1:0] red_node, red_par, red_a, red_b;
  logic mode_q;

  logic [RW-1:0] cur_a, cur_b, par_q;
  logic turn;
  logic [SW-1:0] step;

  logic [STAMP_BITS-1:0] ctr, ctr_plus2, mark_a, mark_b, stamp_q;
  logic [IW-1:0] clr_addr;

  logic [RW-1:0] parent_mem [NODES];
  logic [STAMP_BITS-1:0] stamp_mem [NODES];

  logic stamp_we;
  logic [IW-1:0] stamp_waddr;
  logic [STAMP_BITS-1:0] stamp_wdata;
  logic [RW-1:0] cur_sel;

  assign mark_a    = ctr;
  assign mark_b    = ctr + STAMP_BITS'(1);
  assign ctr_plus2 = ctr + STAMP_BITS'(2);
  assign cur_sel   = turn ? cur_b : cur_a;

  // Input capture with quotients, then remainders on the reduce cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= mode;
      raw_node <= node;
      raw_par  <= parent_value;
      raw_a    <= first_vertex;
      raw_b    <= second_vertex;
      quo_node <= mod_quot(node);
      quo_par  <= mod_quot(parent_value);
      quo_a    <= mod_quot(first_vertex);
      quo_b    <= mod_quot(second_vertex);
    end else if (cmd.reduce_step) begin
      red_node <= mod_rem(raw_node, quo_node);
      red_par  <= mod_rem(raw_par, quo_par);
      red_a    <= mod_rem(raw_a, quo_a);
      red_b    <= mod_rem(raw_b, quo_b);
    end
  end

  // Climber positions, turn and step count
  always_ff @(posedge clk) begin
    if (cmd.mark_first) begin
      cur_a <= red_a;
      cur_b <= red_b;
      turn  <= 1'b0;
      step  <= '0;
    end else if (cmd.climb_advance) begin
      if (turn) begin
        cur_b <= par_q;
      end else begin
        cur_a <= par_q;
      end
      turn <= ~turn;
      step <= step + SW'(1);
    end
  end

  // Parent table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_write) begin
      parent_mem[IW'(red_node)] <= red_par;
    end
    if (cmd.par_read) begin
      par_q <= parent_mem[IW'(cur_sel)];
    end
  end

  // Stamp write source
  always_comb begin
    stamp_we    = 1'b1;
    stamp_waddr = clr_addr;
    stamp_wdata = '0;
    if (cmd.clear_step) begin
      stamp_waddr = clr_addr;
      stamp_wdata = '0;
    end else if (cmd.mark_first) begin
      stamp_waddr = IW'(red_a);
      stamp_wdata = mark_a;
    end else if (cmd.mark_second) begin
      stamp_waddr = IW'(red_b);
      stamp_wdata = mark_b;
    end else if (cmd.climb_advance) begin
      stamp_waddr = IW'(par_q);
      stamp_wdata = turn ? mark_b : mark_a;
    end else begin
      stamp_we = 1'b0;
    end
  end

  // Stamp store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    if (cmd.stamp_read) begin
      stamp_q <= stamp_mem[IW'(par_q)];
    end
  end

  // Stamp counter and clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr      <= STAMP_INIT;
      clr_addr <= '0;
    end else begin
      if (cmd.finish) begin
        ctr <= (ctr_plus2 == '0) ? STAMP_INIT : ctr_plus2;
      end
      if (cmd.clear_step) begin
        clr_addr <= (clr_addr == ADDR_LAST) ? '0 : clr_addr + IW'(1);
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (cmd.fin_kind)
        FIN_EQUAL: begin
          ancestor <= VW'(red_a);
          found    <= 1'b1;
        end
        FIN_MET: begin
          ancestor <= VW'(par_q);
          found    <= 1'b1;
        end
        default: begin
          ancestor <= '0;
          found    <= 1'b0;
        end
      endcase
    end
  end

  // Status back to the controller
  assign status.is_load     = ~mode_q;
  assign status.same_vertex = (red_a == red_b);
  assign status.met         = (stamp_q == (turn ? mark_a : mark_b));
  assign status.step_last   = (step == STEP_LAST);
  assign status.clear_last  = (clr_addr == ADDR_LAST);
  assign status.wrap        = (ctr_plus2 == '0);

endmodule

// File: src/tlca_ctrl.sv
`timescale 1ns / 1ps

module tlca_ctrl import tlca_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_REDUCE,
    S_DISPATCH,
    S_MARK_B,
    S_RD_PAR,
    S_RD_STAMP,
    S_CHECK
  } state_t;

  state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.fin_kind = FIN_MISS;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_REDUCE;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_REDUCE: begin
        cmd.reduce_step = 1'b1;
        state_next      = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (status.is_load) begin
          cmd.load_write = 1'b1;
          state_next     = S_IDLE;
        end else if (status.same_vertex) begin
          cmd.finish   = 1'b1;
          cmd.fin_kind = FIN_EQUAL;
          state_next   = status.wrap ? S_CLEAR : S_IDLE;
        end else begin
          cmd.mark_first = 1'b1;
          state_next     = S_MARK_B;
        end
      end
      S_MARK_B: begin
        cmd.mark_second = 1'b1;
        state_next      = S_RD_PAR;
      end
      S_RD_PAR: begin
        cmd.par_read = 1'b1;
        state_next   = S_RD_STAMP;
      end
      S_RD_STAMP: begin
        cmd.stamp_read = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        if (status.met) begin
          cmd.finish   = 1'b1;
          cmd.fin_kind = FIN_MET;
          state_next   = status.wrap ? S_CLEAR : S_IDLE;
        end else begin
          cmd.climb_advance = 1'b1;
          if (status.step_last) begin
            cmd.finish   = 1'b1;
            cmd.fin_kind = FIN_MISS;
            state_next   = status.wrap ? S_CLEAR : S_IDLE;
          end else begin
            state_next = S_RD_PAR;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered outputs; reset starts the stamp clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= cmd.finish;
    end
  end

endmodule

// File: src/tree_lca_alternating_climb.sv
// Sequence: a load keeps busy high through vertex reduction and the parent table write. A query
// runs vertex reduction and dispatch (which marks the first vertex), marks the second vertex, then
// repeats climb steps (parent read, stamp read, compare and mark) until the climbers meet; equal
// vertices finish at dispatch, and a miss runs all 2*NODES steps.
// Throughput: one item at a time, start taken only while busy is low; the receiver cannot stall.
// Reset (rst, synchronous) clears the stamp store with busy high; so does a wrap.
`timescale 1ns / 1ps

`include "tree_lca_alternating_climb_defines.svh"

module tree_lca_alternating_climb import tlca_pkg::*; #(
  parameter int NODES      = 1024,
  parameter int STAMP_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic          mode,
  input  logic [VW-1:0] node,
  input  logic [VW-1:0] parent_value,
  input  logic [VW-1:0] first_vertex,
  input  logic [VW-1:0] second_vertex,
  output logic          done,
  output logic [VW-1:0] ancestor,
  output logic          found
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  tlca_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Tables, climbers and result registers
  tlca_datapath #(
    .NODES      (NODES),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .node          (node),
    .parent_value  (parent_value),
    .first_vertex  (first_vertex),
    .second_vertex (second_vertex),
    .ancestor      (ancestor),
    .found         (found)
  );

  // A transfer always makes the block busy next cycle
  `TLCA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
  // No result can appear right after an idle cycle
  `TLCA_ASSERT_NEXT(a_idle_no_done, !busy, !done, "result strobe after idle cycle")
  // A miss reports ancestor zero
  `TLCA_ASSERT_NOW(a_miss_zero, done && !found, ancestor == '0, "miss with nonzero ancestor")
  // Result strobe lasts a single cycle
  `TLCA_ASSERT_NOW(a_done_one_shot, done, !$past(done), "result strobe longer than one cycle")

endmodule
